/* hw/rtl/weighted_priority_lottery_scheduler_macros.svh */
// assertion helpers for the scheduler top level
`ifndef WEIGHTED_PRIORITY_LOTTERY_SCHEDULER_MACROS_SVH
`define WEIGHTED_PRIORITY_LOTTERY_SCHEDULER_MACROS_SVH

// same-cycle implication, masked while reset is high
`define WPLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define WPLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/wpls_pkg.sv */
package wpls_pkg;

   // field widths of the beats
   localparam int OPCODE_W     = 2;
   localparam int TASK_W       = 6;
   localparam int LEVEL_W      = 2;
   localparam int STATUS_W     = 2;
   localparam int RAND_FIELD_W = 31;

   // sizing
   localparam int TASKS        = 64;
   localparam int LEVELS       = 3;
   localparam int RANDOM_WIDTH = 31;
   localparam int COUNT_W      = $clog2(TASKS + 1);
   localparam int WEIGHT_W     = $clog2((19 * TASKS) / 4 + 1);
   localparam int DIV_CNT_W    = $clog2(RANDOM_WIDTH);

   localparam logic [TASK_W:0] TASK_LIMIT = (TASK_W + 1)'(TASKS);

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PICK   = 2'd2;

   // levels
   localparam logic [LEVEL_W-1:0] LVL_HIGH = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IDLE      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [TASK_W-1:0]       task_id;
      logic [LEVEL_W-1:0]      priority_level;
      logic [RAND_FIELD_W-1:0] random_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   picked_task;
      logic [LEVEL_W-1:0]  picked_level;
      logic                idle_flag;
   } rsp_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_UNLINK = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_SELECT = 7'b0010000,
      S_ROTATE = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic unlink;
      logic select;
      logic rotate;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                all_empty;
      logic                div_last;
      logic                rotate_needed;
      logic                out_free;
   } stat_type;

   function automatic logic task_in_range(input logic [TASK_W-1:0] id);
      return {1'b0, id} < TASK_LIMIT;
   endfunction

endpackage

/* hw/rtl/wpls_req_if.sv */
interface wpls_req_if;
   logic               valid;
   logic               ready;
   wpls_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/wpls_rsp_if.sv */
interface wpls_rsp_if;
   logic               valid;
   logic               ready;
   wpls_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/wpls_ram.sv */
module wpls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/wpls_controller.sv */
module wpls_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  wpls_pkg::stat_type stat,
   output wpls_pkg::cmd_type  cmd,
   output logic               req_ready
);

   wpls_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpls_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         wpls_pkg::S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = wpls_pkg::S_EXEC;
            end
         end
         wpls_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (stat.op == wpls_pkg::OP_REMOVE) begin
               state_in = wpls_pkg::S_UNLINK;
            end else if (stat.op == wpls_pkg::OP_PICK && !stat.all_empty) begin
               state_in = wpls_pkg::S_DIV;
            end else begin
               state_in = wpls_pkg::S_RESP;
            end
         end
         wpls_pkg::S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = wpls_pkg::S_RESP;
         end
         wpls_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = wpls_pkg::S_SELECT;
            end
         end
         wpls_pkg::S_SELECT: begin
            cmd.select = 1'b1;
            state_in   = stat.rotate_needed ? wpls_pkg::S_ROTATE : wpls_pkg::S_RESP;
         end
         wpls_pkg::S_ROTATE: begin
            cmd.rotate = 1'b1;
            state_in   = wpls_pkg::S_RESP;
         end
         wpls_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = wpls_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wpls_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/wpls_datapath.sv */
module wpls_datapath (
   input  logic               clock,
   input  logic               reset,
   input  wpls_pkg::cmd_type  cmd,
   input  wpls_pkg::req_type  req_payload,
   input  logic               rsp_ready,
   output wpls_pkg::stat_type stat,
   output logic               rsp_valid,
   output wpls_pkg::rsp_type  rsp_payload
);

   // captured item
   logic [wpls_pkg::OPCODE_W-1:0]     op_ff, op_in;
   logic [wpls_pkg::TASK_W-1:0]       id_ff, id_in;
   logic [wpls_pkg::LEVEL_W-1:0]      lv_ff, lv_in;
   logic [wpls_pkg::RANDOM_WIDTH-1:0] draw_ff, draw_in;

   // divider
   logic [wpls_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [wpls_pkg::WEIGHT_W-1:0]     rem_ff, rem_in;
   logic [wpls_pkg::WEIGHT_W-1:0]     total_ff, total_in;

   // pick in flight
   logic [wpls_pkg::LEVEL_W-1:0]      sel_ff, sel_in;
   logic [wpls_pkg::TASK_W-1:0]       pick_ff, pick_in;

   // queue heads, tails, fill levels
   logic [wpls_pkg::TASK_W-1:0]  head_ff  [wpls_pkg::LEVELS];
   logic [wpls_pkg::TASK_W-1:0]  head_in  [wpls_pkg::LEVELS];
   logic [wpls_pkg::TASK_W-1:0]  tail_ff  [wpls_pkg::LEVELS];
   logic [wpls_pkg::TASK_W-1:0]  tail_in  [wpls_pkg::LEVELS];
   logic [wpls_pkg::COUNT_W-1:0] count_ff [wpls_pkg::LEVELS];
   logic [wpls_pkg::COUNT_W-1:0] count_in [wpls_pkg::LEVELS];
   logic [wpls_pkg::TASKS-1:0]   queued_ff, queued_in;

   // results
   wpls_pkg::rsp_type res_ff, res_in, out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   // weights
   logic [wpls_pkg::WEIGHT_W-1:0] w_low, w_mid, w_high, w_lowmid, w_total;
   logic                          all_empty;

   // divider step
   logic [wpls_pkg::WEIGHT_W:0]   trial, diff;
   logic                          fits;

   // level selection
   logic [wpls_pkg::LEVEL_W-1:0]  sel_draw, sel_pick, sel_spare;
   logic [wpls_pkg::TASK_W-1:0]   head_pick;

   // ram ports
   logic                          next_we, prev_we, lvl_we;
   logic [wpls_pkg::TASK_W-1:0]   next_wa, next_wd, next_ra, next_rd;
   logic [wpls_pkg::TASK_W-1:0]   prev_wa, prev_wd, prev_rd;
   logic [wpls_pkg::LEVEL_W-1:0]  lvl_rd;

   // operation checks
   logic add_ok, lvl_empty, remove_ok, add_cmd;
   logic [wpls_pkg::TASK_W-1:0]   prev_id, after;

   assign w_low    = wpls_pkg::WEIGHT_W'(count_ff[wpls_pkg::LVL_LOW]);
   assign w_mid    = wpls_pkg::WEIGHT_W'(count_ff[wpls_pkg::LVL_MID])
                   + wpls_pkg::WEIGHT_W'(count_ff[wpls_pkg::LVL_MID] >> 1);
   assign w_high   = (wpls_pkg::WEIGHT_W'(count_ff[wpls_pkg::LVL_HIGH]) << 1)
                   + wpls_pkg::WEIGHT_W'(count_ff[wpls_pkg::LVL_HIGH] >> 2);
   assign w_lowmid = w_low + w_mid;
   assign w_total  = w_lowmid + w_high;

   assign all_empty = (count_ff[wpls_pkg::LVL_HIGH] == '0)
                   && (count_ff[wpls_pkg::LVL_MID] == '0)
                   && (count_ff[wpls_pkg::LVL_LOW] == '0);

   // restoring remainder, one draw bit per step
   assign trial = {rem_ff, draw_ff[wpls_pkg::RANDOM_WIDTH-1]};
   assign fits  = trial >= {1'b0, total_ff};
   assign diff  = trial - {1'b0, total_ff};

   always_comb begin
      priority if (rem_ff < w_low && count_ff[wpls_pkg::LVL_LOW] != '0) begin
         sel_draw = wpls_pkg::LVL_LOW;
      end else if (rem_ff < w_lowmid && count_ff[wpls_pkg::LVL_MID] != '0) begin
         sel_draw = wpls_pkg::LVL_MID;
      end else begin
         sel_draw = wpls_pkg::LVL_HIGH;
      end
      priority if (count_ff[wpls_pkg::LVL_LOW] != '0) begin
         sel_spare = wpls_pkg::LVL_LOW;
      end else if (count_ff[wpls_pkg::LVL_MID] != '0) begin
         sel_spare = wpls_pkg::LVL_MID;
      end else begin
         sel_spare = wpls_pkg::LVL_HIGH;
      end
      sel_pick = (count_ff[sel_draw] == '0) ? sel_spare : sel_draw;
   end

   assign head_pick = head_ff[sel_pick];

   assign add_cmd   = cmd.exec && (op_ff == wpls_pkg::OP_ADD);
   assign add_ok    = wpls_pkg::task_in_range(id_ff) && !queued_ff[id_ff];
   assign lvl_empty = count_ff[lv_ff] == '0;
   assign prev_id   = prev_rd;
   assign after     = next_rd;
   assign remove_ok = wpls_pkg::task_in_range(id_ff) && queued_ff[id_ff] && (lvl_rd == lv_ff);

   // register next values
   always_comb begin
      op_in        = op_ff;
      id_in        = id_ff;
      lv_in        = lv_ff;
      draw_in      = draw_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      sel_in       = sel_ff;
      pick_in      = pick_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      queued_in    = queued_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (cmd.capture) begin
         op_in   = req_payload.opcode;
         id_in   = req_payload.task_id;
         lv_in   = (req_payload.priority_level > wpls_pkg::LVL_LOW)
                 ? wpls_pkg::LVL_LOW : req_payload.priority_level;
         draw_in = req_payload.random_value[wpls_pkg::RANDOM_WIDTH-1:0];
         cnt_in  = wpls_pkg::DIV_CNT_W'(wpls_pkg::RANDOM_WIDTH - 1);
         rem_in  = '0;
      end

      if (cmd.exec) begin
         total_in = w_total;
         res_in   = '0;
         unique case (op_ff)
            wpls_pkg::OP_ADD: begin
               priority if (!wpls_pkg::task_in_range(id_ff)) begin
                  res_in.status = wpls_pkg::ST_NOT_FOUND;
               end else if (queued_ff[id_ff]) begin
                  res_in.status = wpls_pkg::ST_DUPLICATE;
               end else begin
                  if (lvl_empty) begin
                     head_in[lv_ff] = id_ff;
                  end
                  tail_in[lv_ff]   = id_ff;
                  count_in[lv_ff]  = count_ff[lv_ff] + 1'b1;
                  queued_in[id_ff] = 1'b1;
               end
            end
            wpls_pkg::OP_PICK: begin
               if (all_empty) begin
                  res_in.status    = wpls_pkg::ST_IDLE;
                  res_in.idle_flag = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in  = fits ? diff[wpls_pkg::WEIGHT_W-1:0] : trial[wpls_pkg::WEIGHT_W-1:0];
         draw_in = draw_ff << 1;
         cnt_in  = cnt_ff - 1'b1;
      end

      if (cmd.unlink) begin
         res_in = '0;
         if (!remove_ok) begin
            res_in.status = wpls_pkg::ST_NOT_FOUND;
         end else begin
            if (head_ff[lv_ff] == id_ff) begin
               head_in[lv_ff] = after;
            end
            if (tail_ff[lv_ff] == id_ff) begin
               tail_in[lv_ff] = prev_id;
            end
            if (count_ff[lv_ff] != '0) begin
               count_in[lv_ff] = count_ff[lv_ff] - 1'b1;
            end
            queued_in[id_ff] = 1'b0;
         end
      end

      if (cmd.select) begin
         sel_in              = sel_pick;
         pick_in             = head_pick;
         res_in.status       = wpls_pkg::ST_DONE;
         res_in.picked_task  = head_pick;
         res_in.picked_level = sel_pick;
         res_in.idle_flag    = 1'b0;
      end

      // head moves on to its successor, old head goes behind the tail
      if (cmd.rotate) begin
         head_in[sel_ff] = next_rd;
         tail_in[sel_ff] = pick_ff;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_in       = res_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // link table write ports
   always_comb begin
      next_we = 1'b0;
      next_wa = tail_ff[lv_ff];
      next_wd = id_ff;
      prev_we = 1'b0;
      prev_wa = id_ff;
      prev_wd = tail_ff[lv_ff];
      if (add_cmd && add_ok && !lvl_empty) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end
      if (cmd.unlink && remove_ok) begin
         if (head_ff[lv_ff] != id_ff && wpls_pkg::task_in_range(prev_id)) begin
            next_we = 1'b1;
            next_wa = prev_id;
            next_wd = after;
         end
         if (tail_ff[lv_ff] != id_ff && wpls_pkg::task_in_range(after)) begin
            prev_we = 1'b1;
            prev_wa = after;
            prev_wd = prev_id;
         end
      end
      if (cmd.rotate) begin
         next_we = 1'b1;
         next_wa = tail_ff[sel_ff];
         next_wd = pick_ff;
         prev_we = 1'b1;
         prev_wa = pick_ff;
         prev_wd = tail_ff[sel_ff];
      end
   end

   assign lvl_we  = add_cmd && add_ok;
   assign next_ra = cmd.select ? head_pick : id_ff;

   wpls_ram #(.WIDTH(wpls_pkg::TASK_W), .DEPTH(wpls_pkg::TASKS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (next_ra),
      .rd_data (next_rd)
   );

   wpls_ram #(.WIDTH(wpls_pkg::TASK_W), .DEPTH(wpls_pkg::TASKS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (id_ff),
      .rd_data (prev_rd)
   );

   wpls_ram #(.WIDTH(wpls_pkg::LEVEL_W), .DEPTH(wpls_pkg::TASKS)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (id_ff),
      .wr_data (lv_ff),
      .rd_addr (id_ff),
      .rd_data (lvl_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '{default: '0};
         queued_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         queued_ff    <= queued_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      id_ff    <= id_in;
      lv_ff    <= lv_in;
      draw_ff  <= draw_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      total_ff <= total_in;
      sel_ff   <= sel_in;
      pick_ff  <= pick_in;
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign stat.op            = op_ff;
   assign stat.all_empty     = all_empty;
   assign stat.div_last      = cnt_ff == '0;
   assign stat.rotate_needed = count_ff[sel_pick] > wpls_pkg::COUNT_W'(1);
   assign stat.out_free      = !out_valid_ff || rsp_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* hw/rtl/weighted_priority_lottery_scheduler.sv */
// an add runs execute then response, a remove execute, unlink and response,
// a pick execute, divide, select, rotate (skipped when its level holds a single
// task) and response, an empty pick execute then response; one item at a time
// the remainder unit takes one draw bit per cycle over 31 bits
// reset (synchronous, active high) clears the fill counts, queued flags, fsm and
// output valid; link tables need no clearing
`include "weighted_priority_lottery_scheduler_macros.svh"

module weighted_priority_lottery_scheduler (
   input logic       clock,
   input logic       reset,
   wpls_req_if.sink  req_bus,
   wpls_rsp_if.source rsp_bus
);

   // command and status between sequencer and datapath
   wpls_pkg::cmd_type  cmd;
   wpls_pkg::stat_type stat;
   logic               req_ready;

   // request side only opens when the sequencer is idle; the response
   // register lets a finished beat wait while the next item is taken
   assign req_bus.ready = req_ready;

   // sequencer: idle, execute, then unlink for remove, or divide,
   // select and rotate for pick, then hand over to the output register
   wpls_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // datapath: queue heads and tails, fill counts, queued flags,
   // link tables in ram, remainder unit and output register
   wpls_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_bus.payload),
      .rsp_ready   (rsp_bus.ready),
      .stat        (stat),
      .rsp_valid   (rsp_bus.valid),
      .rsp_payload (rsp_bus.payload)
   );

   // an accepted beat keeps the block busy, with request ready held low
   `WPLS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready ##1 !req_bus.ready, "request taken while busy")

   // idle flag only with idle status and no picked task
   `WPLS_ASSERT_NOW(a_idle_flag_clean, clock, reset, rsp_bus.valid && rsp_bus.payload.idle_flag, rsp_bus.payload.status == wpls_pkg::ST_IDLE && rsp_bus.payload.picked_task == '0 && rsp_bus.payload.picked_level == '0, "idle beat carries pick data")

   // failed add or remove reports no pick
   `WPLS_ASSERT_NOW(a_fail_no_pick, clock, reset, rsp_bus.valid && (rsp_bus.payload.status == wpls_pkg::ST_NOT_FOUND || rsp_bus.payload.status == wpls_pkg::ST_DUPLICATE), rsp_bus.payload.picked_task == '0 && !rsp_bus.payload.idle_flag, "failed beat carries pick data")

endmodule
